// ----- sv/hash_set_table_assert.svh -----
// Assertion macros for the hash set table.
`ifndef HASH_SET_TABLE_ASSERT_SVH
`define HASH_SET_TABLE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define HST_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hash_set_table: check failed");

// Next-cycle implication, checked outside reset.
`define HST_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hash_set_table: check failed");

`endif

// ----- sv/hst_pkg.sv -----
`timescale 1ns / 1ps
package hst_pkg;

  // Table geometry. BUCKETS must be a power of two: the bucket is the key's low bits.
  localparam int unsigned BUCKETS = 256;
  localparam int unsigned WAYS    = 4;
  localparam int unsigned SLOTS   = BUCKETS * WAYS;

  localparam int unsigned KEY_W   = 31;
  localparam int unsigned OP_W    = 2;
  localparam int unsigned IDX_W   = $clog2(BUCKETS);
  localparam int unsigned ENT_W   = KEY_W + 1;      // key plus valid mark
  localparam int unsigned ROW_W   = WAYS * ENT_W;
  localparam int unsigned CNT_W   = $clog2(SLOTS + 1);

  localparam int unsigned IN_TDATA_W  = ((KEY_W + 7) / 8) * 8;
  localparam int unsigned OUT_TDATA_W = 8;

  localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_TEST   = 2'd2;

  typedef struct packed {
    logic accept;        // request taken, bucket read issued
    logic look;          // bucket row valid, compare and write back
    logic clr;           // clearing pass writes one row
    logic ld_out;        // load output register
    logic out_from_pend; // source of output load is the pending register
    logic ld_pend;       // park result while output is occupied
  } hst_cmd_t;

  typedef struct packed {
    logic             clr_last;
    logic [CNT_W-1:0] count;
  } hst_sts_t;

endpackage

// ----- sv/hst_ram.sv -----
`timescale 1ns / 1ps
module hst_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- sv/hst_ctrl.sv -----
`timescale 1ns / 1ps
module hst_ctrl
  import hst_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  output logic     out_tvalid,
  input  logic     out_tready,
  input  hst_sts_t sts,
  output hst_cmd_t cmd
);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_LOOK  = 2'd2;
  localparam logic [1:0] S_PEND  = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_LOOK;
        end
      end
      S_LOOK: begin
        cmd.look = 1'b1;
        if (!out_valid_r || out_tready) begin
          cmd.ld_out    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          cmd.ld_pend = 1'b1;
          state_nxt   = S_PEND;
        end
      end
      S_PEND: begin
        if (out_tready) begin
          cmd.ld_out        = 1'b1;
          cmd.out_from_pend = 1'b1;
          out_valid_nxt     = 1'b1;
          state_nxt         = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

endmodule

// ----- sv/hst_dp.sv -----
`timescale 1ns / 1ps
module hst_dp
  import hst_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  hst_cmd_t         cmd,
  input  logic [OP_W-1:0]  in_op,
  input  logic [KEY_W-1:0] in_key,
  output hst_sts_t         sts,
  output logic             out_present,
  output logic             out_full
);

  logic [OP_W-1:0]  op_r;
  logic [KEY_W-1:0] key_r;
  logic [IDX_W-1:0] clr_idx_r, clr_idx_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             out_present_r, out_full_r;
  logic             pend_present_r, pend_full_r;

  logic [ROW_W-1:0] row_rd, row_new, ram_wdata;
  logic [IDX_W-1:0] ram_waddr;
  logic             ram_we;

  logic [WAYS-1:0]  match, free, hit_oh, free_oh;
  logic             hit, have_free, add_wr, rem_wr, full;

  hst_ram #(
    .WIDTH (ROW_W),
    .DEPTH (BUCKETS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.accept),
    .raddr (in_key[IDX_W-1:0]),
    .rdata (row_rd)
  );

  // Compare all ways of the bucket; pick lowest hit and lowest free way.
  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      match[w] = row_rd[w*ENT_W + KEY_W] && (row_rd[w*ENT_W +: KEY_W] == key_r);
      free[w]  = !row_rd[w*ENT_W + KEY_W];
    end
    hit_oh    = match & (~match + WAYS'(1));
    free_oh   = free & (~free + WAYS'(1));
    hit       = |match;
    have_free = |free;
  end

  always_comb begin
    add_wr = 1'b0;
    rem_wr = 1'b0;
    full   = 1'b0;
    unique case (op_r)
      OP_ADD: begin
        add_wr = !hit && have_free;
        full   = !hit && !have_free;
      end
      OP_REMOVE: rem_wr = hit;
      default: ;  // test, and the unused code, change nothing
    endcase
    row_new = row_rd;
    for (int w = 0; w < WAYS; w++) begin
      if (add_wr && free_oh[w]) begin
        row_new[w*ENT_W +: ENT_W] = {1'b1, key_r};
      end
      if (rem_wr && hit_oh[w]) begin
        row_new[w*ENT_W + KEY_W] = 1'b0;
      end
    end
  end

  assign ram_we    = cmd.clr || (cmd.look && (add_wr || rem_wr));
  assign ram_waddr = cmd.clr ? clr_idx_r : key_r[IDX_W-1:0];
  assign ram_wdata = cmd.clr ? '0 : row_new;

  always_comb begin
    clr_idx_nxt = clr_idx_r;
    count_nxt   = count_r;
    if (cmd.clr) begin
      clr_idx_nxt = clr_idx_r + IDX_W'(1);
    end
    if (cmd.look && add_wr) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (cmd.look && rem_wr && (count_r != '0)) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_idx_r <= '0;
      count_r   <= '0;
    end else begin
      clr_idx_r <= clr_idx_nxt;
      count_r   <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r  <= in_op;
      key_r <= in_key;
    end
    if (cmd.ld_pend) begin
      pend_present_r <= hit;
      pend_full_r    <= full;
    end
    if (cmd.ld_out) begin
      out_present_r <= cmd.out_from_pend ? pend_present_r : hit;
      out_full_r    <= cmd.out_from_pend ? pend_full_r : full;
    end
  end

  assign sts.clr_last = (clr_idx_r == IDX_W'(BUCKETS - 1));
  assign sts.count    = count_r;
  assign out_present  = out_present_r;
  assign out_full     = out_full_r;

endmodule

// ----- sv/hash_set_table.sv -----
`timescale 1ns / 1ps
// channel | ports                         | tdata / tuser fields, low bit first
// --------+-------------------------------+--------------------------------------------
// in      | in_tvalid in_tready in_tdata  | tdata: key[30:0], 0 pad; tuser: op[1:0]
//         | in_tuser                      |
// out     | out_tvalid out_tready         | tdata: was_present, bucket_full, 0 pad
//         | out_tdata                     |
// One item at a time: the accept cycle reads the bucket row, the next cycle compares
// the ways and writes the row back; the single bucket RAM's read-modify-write forces this.
// out_tvalid is set at the end of the lookup cycle, unless out still holds an untaken item.
// After reset a clearing pass zeroes all BUCKETS (256) rows of the bucket RAM, in_tready low.
// With out stalled, the next finished result parks in a pending register and
// in_tready stays low until out takes the item it holds.
`include "hash_set_table_assert.svh"
module hash_set_table
  import hst_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // key[30:0], pad
  input  logic [OP_W-1:0]        in_tuser,   // op[1:0]
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata   // was_present, bucket_full, pad
);

  hst_cmd_t cmd;
  hst_sts_t sts;
  logic     out_present, out_full;

  // Sequencer: clearing pass, accept, lookup, output / pending hand-off.
  hst_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  // Bucket RAM, way compare, row update, entry count, result registers.
  hst_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .in_op       (in_tuser),
    .in_key      (in_tdata[KEY_W-1:0]),
    .sts         (sts),
    .out_present (out_present),
    .out_full    (out_full)
  );

  assign out_tdata = {{(OUT_TDATA_W-2){1'b0}}, out_full, out_present};

  // One item in flight: the cycle after an accept is always the lookup.
  `HST_ASSERT_NEXT(a_one_in_flight, in_tvalid && in_tready, !in_tready)
  // At the end of each accepted item's lookup cycle, out_tvalid is high.
  `HST_ASSERT_NEXT(a_result_timing, in_tvalid && in_tready, ##1 out_tvalid)
  // A failed add never reports the key as present.
  `HST_ASSERT_NOW(a_full_not_hit, out_tvalid, !(out_present && out_full))
  // Entry count stays within the table.
  `HST_ASSERT_NOW(a_count_range, 1'b1, sts.count <= CNT_W'(SLOTS))

endmodule
